### rtl/core/itf_barcode_module_decoder_macros.svh
`ifndef ITF_BARCODE_MODULE_DECODER_MACROS_SVH
`define ITF_BARCODE_MODULE_DECODER_MACROS_SVH

// same-cycle implication, off while reset is high
`define ITF_BMD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itf_bmd: check failed");

// next-cycle implication, also active during reset
`define ITF_BMD_ASSERT_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("itf_bmd: check failed");

`endif

### rtl/core/itf_bmd_pkg.sv
`default_nettype none

package itf_bmd_pkg;

   localparam int         RUNS_PER_PAIR    = 10;
   localparam logic [4:0] MODULES_PER_PAIR = 5'd18;
   localparam logic [2:0] HEADER_LEN       = 3'd4;
   localparam logic [3:0] START_PATTERN    = 4'b1010;
   localparam logic [2:0] WIDE_RUN         = 3'd3;
   localparam logic [2:0] LONG_RUN         = 3'd4;
   localparam logic [6:0] MAX_PAIRS_RESET  = 7'd32;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_PAIRS  = 3'b010,
      PH_DONE   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAIR  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic module_bit;
      logic start_symbol;
   } item_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [3:0] first_digit;
      logic [3:0] second_digit;
      logic [7:0] digit_count;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       emit;
      result_type result;
   } core_out_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] digit;
   } digit_type;

   function automatic digit_type match_symbol(input logic [4:0] code);
      digit_type d;
      d.hit   = 1'b1;
      d.digit = 4'd0;
      unique case (code)
         5'b00110: d.digit = 4'd0;
         5'b10001: d.digit = 4'd1;
         5'b01001: d.digit = 4'd2;
         5'b11000: d.digit = 4'd3;
         5'b00101: d.digit = 4'd4;
         5'b10100: d.digit = 4'd5;
         5'b01100: d.digit = 4'd6;
         5'b00011: d.digit = 4'd7;
         5'b10010: d.digit = 4'd8;
         5'b01010: d.digit = 4'd9;
         default:  d.hit   = 1'b0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/core/itf_bmd_core.sv
`default_nettype none

module itf_bmd_core
   import itf_bmd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [6:0]   csr_wr_data,
   input  wire logic         step,
   input  wire item_type     item,
   output core_out_type      core_out
);

   logic [6:0] max_pairs_ff;
   phase_type  phase_ff, phase_in, phase_eff;
   logic [3:0] hdr_bits_ff, hdr_bits_in, hdr_bits_eff;
   logic [2:0] hdr_cnt_ff, hdr_cnt_in, hdr_cnt_eff;
   logic [4:0] bip_ff, bip_in, bip_eff;
   logic       prev_ff, prev_in, prev_eff;
   logic [6:0] pairs_ff, pairs_in, pairs_eff, pairs_inc;
   logic [2:0] runs_ff  [RUNS_PER_PAIR];
   logic [2:0] runs_in  [RUNS_PER_PAIR];
   logic [2:0] runs_eff [RUNS_PER_PAIR];
   logic [2:0] runs_sh  [RUNS_PER_PAIR];
   logic       shift;
   logic [4:0] bars, spaces;
   digit_type  bar_dig, space_dig;

   always_comb begin
      phase_eff    = item.start_symbol ? PH_HEADER : phase_ff;
      hdr_bits_eff = item.start_symbol ? 4'd0 : hdr_bits_ff;
      hdr_cnt_eff  = item.start_symbol ? 3'd0 : hdr_cnt_ff;
      bip_eff      = item.start_symbol ? 5'd0 : bip_ff;
      prev_eff     = item.start_symbol ? 1'b0 : prev_ff;
      pairs_eff    = item.start_symbol ? 7'd0 : pairs_ff;
      for (int i = 0; i < RUNS_PER_PAIR; i++) begin
         runs_eff[i] = item.start_symbol ? 3'd0 : runs_ff[i];
      end

      // run-length update
      shift = item.module_bit != prev_eff;
      for (int i = RUNS_PER_PAIR - 1; i > 0; i--) begin
         runs_sh[i] = shift ? runs_eff[i-1] : runs_eff[i];
      end
      runs_sh[0] = shift ? 3'd0 : runs_eff[0];
      if (runs_sh[0] < LONG_RUN) begin
         runs_sh[0] = runs_sh[0] + 3'd1;
      end
      for (int k = 0; k < 5; k++) begin
         bars[k]   = runs_sh[2*k+1] == WIDE_RUN;
         spaces[k] = runs_sh[2*k] == WIDE_RUN;
      end
      bar_dig   = match_symbol(bars);
      space_dig = match_symbol(spaces);
      pairs_inc = pairs_eff + 7'd1;

      phase_in    = phase_eff;
      hdr_bits_in = {hdr_bits_eff[2:0], item.module_bit};
      hdr_cnt_in  = hdr_cnt_eff;
      bip_in      = bip_eff;
      prev_in     = prev_eff;
      pairs_in    = pairs_eff;
      runs_in     = runs_eff;

      core_out.emit                = 1'b0;
      core_out.result.result_kind  = KIND_END;
      core_out.result.first_digit  = 4'd0;
      core_out.result.second_digit = 4'd0;
      core_out.result.digit_count  = {pairs_eff, 1'b0};
      core_out.result.last         = 1'b1;

      unique case (phase_eff)
         PH_HEADER: begin
            hdr_cnt_in = hdr_cnt_eff + 3'd1;
            if (hdr_cnt_in == HEADER_LEN) begin
               if (hdr_bits_in != START_PATTERN) begin
                  phase_in                    = PH_DONE;
                  core_out.emit               = 1'b1;
                  core_out.result.result_kind = KIND_ERROR;
               end else begin
                  phase_in = PH_PAIRS;
                  bip_in   = 5'd0;
                  prev_in  = 1'b0;
                  for (int i = 0; i < RUNS_PER_PAIR; i++) begin
                     runs_in[i] = 3'd0;
                  end
                  if (pairs_eff >= max_pairs_ff) begin
                     phase_in      = PH_DONE;
                     core_out.emit = 1'b1;
                  end
               end
            end
         end
         PH_PAIRS: begin
            runs_in = runs_sh;
            prev_in = item.module_bit;
            bip_in  = bip_eff + 5'd1;
            if (runs_sh[0] == LONG_RUN) begin
               phase_in      = PH_DONE;
               core_out.emit = 1'b1;
            end else if (bip_in == MODULES_PER_PAIR) begin
               core_out.emit = 1'b1;
               if (!bar_dig.hit || !space_dig.hit) begin
                  phase_in                    = PH_DONE;
                  core_out.result.result_kind = KIND_ERROR;
               end else begin
                  pairs_in                     = pairs_inc;
                  core_out.result.result_kind  = KIND_PAIR;
                  core_out.result.first_digit  = bar_dig.digit;
                  core_out.result.second_digit = space_dig.digit;
                  core_out.result.digit_count  = {pairs_inc, 1'b0};
                  core_out.result.last         = pairs_inc >= max_pairs_ff;
                  if (pairs_inc >= max_pairs_ff) begin
                     phase_in = PH_DONE;
                  end
                  bip_in  = 5'd0;
                  prev_in = 1'b0;
                  for (int i = 0; i < RUNS_PER_PAIR; i++) begin
                     runs_in[i] = 3'd0;
                  end
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff <= MAX_PAIRS_RESET;
      end else if (csr_wr_en) begin
         max_pairs_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_bits_ff <= 4'd0;
         hdr_cnt_ff  <= 3'd0;
         bip_ff      <= 5'd0;
         prev_ff     <= 1'b0;
         pairs_ff    <= 7'd0;
         for (int i = 0; i < RUNS_PER_PAIR; i++) begin
            runs_ff[i] <= 3'd0;
         end
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_bits_ff <= hdr_bits_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         bip_ff      <= bip_in;
         prev_ff     <= prev_in;
         pairs_ff    <= pairs_in;
         runs_ff     <= runs_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/itf_barcode_module_decoder.sv
// An accepted req word is held in the input register; its rsp word in the result register.
// One module bit per cycle unless rsp stalls; the run-length step is a single pass between them.
// A module bit that ends no pair or message gives no rsp word.
// Reset (synchronous, active high) empties both registers, puts the decoder in the start
// pattern phase with all counts cleared, and sets max_pairs to 32.
`default_nettype none

module itf_barcode_module_decoder
   import itf_bmd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] module_bit, [7:1] zero
   input  wire logic        req_tuser,   // [0] start_symbol
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [3:0] first_digit, [7:4] second_digit,
                                          // [15:8] digit_count
   output logic [1:0]       rsp_tuser,   // [1:0] result_kind
   output logic             rsp_tlast    // last
);

   logic         in_vld_ff, in_vld_in;
   item_type     item_ff;
   logic         advance;
   core_out_type core_out;
   logic         out_vld_ff, out_vld_in;
   result_type   out_ff;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign out_vld_in = (advance && core_out.emit) || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.module_bit   <= req_tdata[0];
         item_ff.start_symbol <= req_tuser;
      end
      if (advance && core_out.emit) begin
         out_ff <= core_out.result;
      end
   end

   itf_bmd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item_ff),
      .core_out    (core_out)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.digit_count, out_ff.second_digit, out_ff.first_digit};
   assign rsp_tuser  = out_ff.result_kind;
   assign rsp_tlast  = out_ff.last;

endmodule

`default_nettype wire

### rtl/core/itf_bmd_checker.sv
`default_nettype none
`include "itf_barcode_module_decoder_macros.svh"

module itf_bmd_checker
   import itf_bmd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   logic        rsp_stall;
   logic [18:0] rsp_word;
   logic        pair_seen;
   logic        pair_ok;

   assign rsp_stall = !reset && rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign pair_seen = rsp_tvalid && rsp_tuser == KIND_PAIR;
   assign pair_ok   = rsp_tdata[3:0] <= 4'd9 && rsp_tdata[7:4] <= 4'd9 && !rsp_tdata[8]
                      && rsp_tdata[15:8] != 8'd0;

   // hold a stalled word
   `ITF_BMD_ASSERT_NEXT(a_rsp_hold, clock, rsp_stall, reset || (rsp_tvalid && $stable(rsp_word)))

   `ITF_BMD_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_tvalid)

   `ITF_BMD_ASSERT_NOW(a_end_is_last, clock, reset, rsp_tvalid && rsp_tuser != KIND_PAIR, rsp_tlast && rsp_tdata[7:0] == 8'd0)

   `ITF_BMD_ASSERT_NOW(a_pair_digits, clock, reset, pair_seen, pair_ok)

endmodule

bind itf_barcode_module_decoder itf_bmd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
